// ===== src/fpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg: shared constants for the fifo page replacement cache
// Default sizes, configuration and result field widths, register reset value.
// ----------------------------------------------------------------------------
package fpr_pkg;

   // default build sizes
   localparam int CAPACITY_DEF  = 16;
   localparam int PAGE_BITS_DEF = 16;

   // cache size register
   localparam int              CFG_W          = 5;
   localparam logic [CFG_W-1:0] CACHE_SIZE_RST = 5'd16;

   // occupancy field of a result beat
   localparam int OCC_W = 5;

endpackage

// ===== src/fifo_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement: fifo page replacement cache
// Looks up one page reference per beat, inserts on a miss, evicts the oldest.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one page number per beat. rsp_* returns one beat per
//   request with hit, eviction flag, evicted page and occupancy.
//   csr_* writes the cache size (slots in use, saturated at CAPACITY); write
//   it only while no request is in flight.
// Scan and throughput:
//   The resident pages sit in a ram and are compared by a single comparator,
//   one slot per cycle with the read pipelined against the compare. A request
//   scans up to the resident count of slots, fewer on a hit; an eviction
//   from a non-empty cache adds a read of the oldest slot. req_tready is low
//   while a request is being processed.
// Reset:
//   Synchronous reset empties the cache and sets the cache size to 16; the
//   ram is not cleared since only written slots are ever compared.
// Stalls:
//   The result register holds its beat while rsp_tready is low; the next
//   request is still accepted and waits at its end for the register to free.
// ----------------------------------------------------------------------------
module fifo_page_replacement #(
   parameter int CAPACITY  = fpr_pkg::CAPACITY_DEF,
   parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // configuration: cache_size
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [fpr_pkg::CFG_W-1:0]                    csr_data,
   // request: page
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   input  logic [((PAGE_BITS+7)/8)*8-1:0]               req_tdata,
   // response: hit, evicted_valid, evicted_page, occupancy
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [((PAGE_BITS+2+fpr_pkg::OCC_W+7)/8)*8-1:0] rsp_tdata
);
   import fpr_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W + 1 : CFG_W + 1;
   localparam int RSP_W = ((PAGE_BITS + 2 + OCC_W + 7) / 8) * 8;
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVRD,
      ST_EVWR,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     oldest_ff, oldest_in;
   logic [CFG_W-1:0]     cache_size_ff, cache_size_in;
   logic [CNT_W-1:0]     issued_ff, issued_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                 res_hit_ff, res_hit_in;
   logic                 res_ev_ff, res_ev_in;
   logic [PAGE_BITS-1:0] res_page_ff, res_page_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [PAGE_BITS-1:0] rd_data;

   logic [CMP_W-1:0]     eff_size;
   logic                 need_evict;
   logic [SUM_W-1:0]     tail_sum;
   logic [IDX_W-1:0]     tail_slot;
   logic [IDX_W-1:0]     oldest_next;
   logic [IDX_W-1:0]     rd_ptr_next;
   logic [CMP_W-1:0]     occ_wide;

   // page slot store
   fpr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (CAPACITY),
      .AW    (IDX_W)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (page_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // effective size and eviction test
   always_comb begin
      if (CMP_W'(cache_size_ff) > CMP_W'(CAPACITY)) begin
         eff_size = CMP_W'(CAPACITY);
      end else begin
         eff_size = CMP_W'(cache_size_ff);
      end
      need_evict = (CMP_W'(count_ff) + CMP_W'(1)) > eff_size;
   end

   // circular slot arithmetic
   always_comb begin
      tail_sum = SUM_W'(oldest_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(CAPACITY)) begin
         tail_sum = tail_sum - SUM_W'(CAPACITY);
      end
      tail_slot = tail_sum[IDX_W-1:0];
      if (oldest_ff == IDX_W'(CAPACITY - 1)) begin
         oldest_next = '0;
      end else begin
         oldest_next = oldest_ff + IDX_W'(1);
      end
      if (rd_ptr_ff == IDX_W'(CAPACITY - 1)) begin
         rd_ptr_next = '0;
      end else begin
         rd_ptr_next = rd_ptr_ff + IDX_W'(1);
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      count_in      = count_ff;
      oldest_in     = oldest_ff;
      cache_size_in = cache_size_ff;
      issued_in     = issued_ff;
      pend_in       = pend_ff;
      rd_ptr_in     = rd_ptr_ff;
      res_hit_in    = res_hit_ff;
      res_ev_in     = res_ev_ff;
      res_page_in   = res_page_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_slot;
      rd_en         = 1'b0;
      rd_addr       = rd_ptr_ff;
      occ_wide      = CMP_W'(count_ff);

      // configuration write
      if (csr_valid) begin
         cache_size_in = csr_data;
      end

      // response beat taken
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               page_in     = req_tdata[PAGE_BITS-1:0];
               issued_in   = '0;
               pend_in     = 1'b0;
               rd_ptr_in   = oldest_ff;
               res_hit_in  = 1'b0;
               res_ev_in   = 1'b0;
               res_page_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // compare the slot read last cycle, issue the next read
            if (pend_ff && rd_data == page_ff) begin
               res_hit_in = 1'b1;
               pend_in    = 1'b0;
               state_in   = ST_DONE;
            end else if (issued_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_addr   = rd_ptr_ff;
               rd_ptr_in = rd_ptr_next;
               issued_in = issued_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if (need_evict) begin
               res_ev_in = 1'b1;
               if (count_ff == '0) begin
                  res_page_in = page_ff;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_EVRD;
               end
            end else begin
               // plain insert at the tail
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_EVRD: begin
            rd_en    = 1'b1;
            rd_addr  = oldest_ff;
            state_in = ST_EVWR;
         end
         ST_EVWR: begin
            // oldest page leaves, new page goes to the tail
            res_page_in = rd_data;
            wr_en       = 1'b1;
            oldest_in   = oldest_next;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_W'({occ_wide[OCC_W-1:0], res_page_ff,
                                       res_ev_ff, res_hit_ff});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         oldest_ff     <= '0;
         cache_size_ff <= CACHE_SIZE_RST;
         issued_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         oldest_ff     <= oldest_in;
         cache_size_ff <= cache_size_in;
         issued_ff     <= issued_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      page_ff      <= page_in;
      rd_ptr_ff    <= rd_ptr_in;
      res_hit_ff   <= res_hit_in;
      res_ev_ff    <= res_ev_in;
      res_page_ff  <= res_page_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== src/fpr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
